@@ hw/rtl/shm_pkg.sv @@
package shm_pkg;

    // Register file indexes with a fixed role.
    localparam logic [3:0] IDX_SI  = 4'd4;
    localparam logic [3:0] IDX_DI  = 4'd5;
    localparam logic [3:0] IDX_DS  = 4'd7;
    localparam logic [3:0] IDX_ES  = 4'd8;
    localparam logic [3:0] IDX_VAL = 4'd9;

    // Status codes reported in the reply to a token.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_LEN   = 2'd1;
    localparam logic [1:0] STAT_VALUE = 2'd2;
    localparam logic [1:0] STAT_INDEX = 2'd3;

    // Characters used by the reply.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EOS   = 8'hFF;

    // Reply slots: four digits, CR, LF, then S, status, CR, LF.
    localparam logic [3:0] SLOT_FIRST_DIGIT = 4'd0;
    localparam logic [3:0] SLOT_LAST_DIGIT  = 4'd3;
    localparam logic [3:0] SLOT_VAL_CR      = 4'd4;
    localparam logic [3:0] SLOT_VAL_LF      = 4'd5;
    localparam logic [3:0] SLOT_S           = 4'd6;
    localparam logic [3:0] SLOT_STATUS      = 4'd7;
    localparam logic [3:0] SLOT_ST_CR       = 4'd8;
    localparam logic [3:0] SLOT_LAST        = 4'd9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic take;
        logic exec;
        logic mem_load;
        logic emit_step;
    } shm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic go_exec;
        logic go_reply;
        logic is_x0;
        logic slot_emit;
        logic slot_last;
        logic out_free;
    } shm_sts_t;

    // Hex digit value; bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Upper-case ASCII for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        r = (d > 4'd9) ? (8'h37 + {4'h0, d}) : (8'h30 + {4'h0, d});
        return r;
    endfunction

endpackage

@@ hw/rtl/shm_ram.sv @@
module shm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/shm_datapath.sv @@
module shm_datapath #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  shm_pkg::shm_cmd_t cmd,
    output shm_pkg::shm_sts_t sts,
    input  logic [7:0]       rx_char,
    output logic [7:0]       tx_char,
    output logic             tx_last,
    output logic             tx_valid,
    input  logic             tx_ready
);
    import shm_pkg::*;

    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  count_reg, count_next;
    logic        started_reg, started_next;
    logic        ovf_reg, ovf_next;
    logic        halted_reg, halted_next;
    logic [15:0] rf_reg [16];
    logic [15:0] rf_next [16];
    logic [3:0]  slot_reg, slot_next;
    logic        print_reg, print_next;
    logic        lead_reg, lead_next;
    logic [1:0]  stat_reg, stat_next;
    logic [MEM_ADDR_BITS-1:0] clr_reg, clr_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_last_reg, out_last_next;
    logic        out_valid_reg, out_valid_next;

    logic        is_end, is_sep;
    logic [7:0]  up_char;
    logic [4:0]  idx_v;
    logic [3:0]  idx;
    logic        head_rwx;
    logic [1:0]  ex_stat;
    logic        ex_print;
    logic        ex_x0, ex_x1;
    logic        hex_ok;
    logic [15:0] hex_acc;
    logic [4:0]  dig;
    logic [19:0] rd_far, wr_far;
    logic        ram_we;
    logic [MEM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [3:0]  nib;
    logic        digit_slot;
    logic        slot_emit;
    logic [7:0]  slot_char;

    // Character classes of the incoming item.
    assign is_end  = (rx_char == CH_NUL) || (rx_char == CH_EOS);
    assign is_sep  = !is_end && (rx_char <= CH_SPACE);
    assign up_char = (rx_char >= 8'h61 && rx_char <= 8'h7A) ? rx_char - 8'h20 : rx_char;

    assign sts.go_exec  = !halted_reg && is_sep && started_reg && !ovf_reg;
    assign sts.go_reply = !halted_reg && ovf_reg && (is_end || is_sep);

    // Token decode.
    assign idx_v    = hex_val(buf_reg[1]);
    assign idx      = idx_v[3:0];
    assign head_rwx = (buf_reg[0] == CH_R) || (buf_reg[0] == CH_W) || (buf_reg[0] == CH_X);

    always_comb begin
        hex_ok  = 1'b1;
        hex_acc = 16'h0;
        dig     = 5'h0;
        for (int i = 0; i < 4; i++) begin
            dig = hex_val(buf_reg[i]);
            if (3'(i) < count_reg) begin
                if (dig[4]) begin
                    hex_ok = 1'b0;
                end
                hex_acc = {hex_acc[11:0], dig[3:0]};
            end
        end
    end

    always_comb begin
        ex_stat  = STAT_OK;
        ex_print = 1'b0;
        ex_x0    = 1'b0;
        ex_x1    = 1'b0;
        if (head_rwx) begin
            if (count_reg != 3'd2) begin
                ex_stat = STAT_LEN;
            end else if (buf_reg[0] == CH_R) begin
                ex_print = 1'b1;
                ex_stat  = idx_v[4] ? STAT_INDEX : STAT_OK;
            end else if (buf_reg[0] == CH_W) begin
                ex_stat = idx_v[4] ? STAT_INDEX : STAT_OK;
            end else if (idx_v == 5'd0) begin
                ex_x0    = 1'b1;
                ex_print = 1'b1;
            end else if (idx_v == 5'd1) begin
                ex_x1 = 1'b1;
            end else if (idx_v != 5'd2) begin
                ex_stat = STAT_INDEX;
            end
        end else if (!hex_ok) begin
            ex_stat = STAT_VALUE;
        end
    end

    assign sts.is_x0 = ex_x0;

    // Memory addressing: segment times 16 plus offset, wrapped.
    assign rd_far = {rf_reg[IDX_DS], 4'h0} + {4'h0, rf_reg[IDX_SI]};
    assign wr_far = {rf_reg[IDX_ES], 4'h0} + {4'h0, rf_reg[IDX_DI]};

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = rf_reg[IDX_VAL][7:0];
        ram_addr  = rd_far[MEM_ADDR_BITS-1:0];
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_wdata = 8'h00;
            ram_addr  = clr_reg;
        end else if (cmd.exec && ex_x1) begin
            ram_we   = 1'b1;
            ram_addr = wr_far[MEM_ADDR_BITS-1:0];
        end
    end

    shm_ram #(
        .WIDTH(8),
        .DEPTH(2 ** MEM_ADDR_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign clr_next       = cmd.clr_step ? clr_reg + 1'b1 : clr_reg;
    assign sts.clear_last = &clr_reg;

    // Reply slot selection.
    assign digit_slot = (slot_reg[3:2] == 2'b00);
    always_comb begin
        unique case (slot_reg[1:0])
            2'd0:    nib = rf_reg[IDX_VAL][15:12];
            2'd1:    nib = rf_reg[IDX_VAL][11:8];
            2'd2:    nib = rf_reg[IDX_VAL][7:4];
            default: nib = rf_reg[IDX_VAL][3:0];
        endcase
    end

    always_comb begin
        if (digit_slot) begin
            slot_emit = print_reg && (lead_reg || nib != 4'h0 || slot_reg == SLOT_LAST_DIGIT);
        end else if (slot_reg == SLOT_VAL_CR || slot_reg == SLOT_VAL_LF) begin
            slot_emit = print_reg;
        end else begin
            slot_emit = 1'b1;
        end
    end

    assign sts.slot_emit = slot_emit;

    always_comb begin
        if (digit_slot) begin
            slot_char = hex_char(nib);
        end else if (slot_reg == SLOT_S) begin
            slot_char = CH_S;
        end else if (slot_reg == SLOT_STATUS) begin
            slot_char = hex_char({2'b00, stat_reg});
        end else if (slot_reg == SLOT_VAL_CR || slot_reg == SLOT_ST_CR) begin
            slot_char = CH_CR;
        end else begin
            slot_char = CH_LF;
        end
    end

    assign sts.slot_last = (slot_reg == SLOT_LAST);
    assign sts.out_free  = !out_valid_reg || tx_ready;

    // Token, register file and reply sequencing.
    always_comb begin
        buf_next     = buf_reg;
        count_next   = count_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        halted_next  = halted_reg;
        rf_next      = rf_reg;
        slot_next    = slot_reg;
        print_next   = print_reg;
        lead_next    = lead_reg;
        stat_next    = stat_reg;

        if (cmd.take && !halted_reg) begin
            if (is_end || (is_sep && ovf_reg)) begin
                if (is_end && !ovf_reg) begin
                    halted_next = 1'b1;
                end
                buf_next     = '{default: 8'h00};
                count_next   = 3'd0;
                started_next = 1'b0;
                ovf_next     = 1'b0;
                slot_next    = SLOT_S;
                print_next   = 1'b0;
                stat_next    = STAT_LEN;
            end else if (!is_sep) begin
                started_next = 1'b1;
                if (count_reg >= 3'd4) begin
                    ovf_next = 1'b1;
                end else begin
                    buf_next[count_reg[1:0]] = up_char;
                    count_next = count_reg + 3'd1;
                end
            end
        end

        if (cmd.exec) begin
            buf_next     = '{default: 8'h00};
            count_next   = 3'd0;
            started_next = 1'b0;
            ovf_next     = 1'b0;
            stat_next    = ex_stat;
            print_next   = ex_print;
            lead_next    = 1'b0;
            slot_next    = ex_print ? SLOT_FIRST_DIGIT : SLOT_S;
            if (head_rwx) begin
                if (count_reg == 3'd2 && !idx_v[4]) begin
                    if (buf_reg[0] == CH_R) begin
                        rf_next[IDX_VAL] = rf_reg[idx];
                    end else if (buf_reg[0] == CH_W) begin
                        rf_next[idx] = rf_reg[IDX_VAL];
                    end else if (ex_x0) begin
                        rf_next[IDX_SI] = rf_reg[IDX_SI] + 16'd1;
                    end else if (ex_x1) begin
                        rf_next[IDX_DI] = rf_reg[IDX_DI] + 16'd1;
                    end
                end
            end else if (hex_ok) begin
                rf_next[IDX_VAL] = hex_acc;
            end
        end

        if (cmd.mem_load) begin
            rf_next[IDX_VAL] = {8'h00, ram_rdata};
        end

        if (cmd.take && sts.go_reply) begin
            lead_next = 1'b0;
        end
        if (cmd.emit_step) begin
            slot_next = slot_reg + 4'd1;
            if (digit_slot && slot_emit) begin
                lead_next = 1'b1;
            end
        end
    end

    // Output register.
    always_comb begin
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !tx_ready;
        if (cmd.emit_step && slot_emit) begin
            out_char_next  = slot_char;
            out_last_next  = sts.slot_last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg       <= '{default: 8'h00};
            count_reg     <= 3'd0;
            started_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            rf_reg        <= '{default: 16'h0000};
            slot_reg      <= SLOT_S;
            print_reg     <= 1'b0;
            lead_reg      <= 1'b0;
            stat_reg      <= STAT_OK;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            buf_reg       <= buf_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            ovf_reg       <= ovf_next;
            halted_reg    <= halted_next;
            rf_reg        <= rf_next;
            slot_reg      <= slot_next;
            print_reg     <= print_next;
            lead_reg      <= lead_next;
            stat_reg      <= stat_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign tx_char  = out_char_reg;
    assign tx_last  = out_last_reg;
    assign tx_valid = out_valid_reg;

endmodule

@@ hw/rtl/shm_ctrl.sv @@
module shm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  shm_pkg::shm_sts_t sts,
    output shm_pkg::shm_cmd_t cmd
);
    import shm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MEMRD = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencing of clear, token execution and reply.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.take = 1'b1;
                    if (sts.go_exec) begin
                        state_next = S_EXEC;
                    end else if (sts.go_reply) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_x0 ? S_MEMRD : S_EMIT;
            end
            S_MEMRD: begin
                cmd.mem_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit_step = !sts.slot_emit || sts.out_free;
                if (cmd.emit_step && sts.slot_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/serial_hex_monitor.sv @@
// Channel   Ports                           Direction  Item
// input     s_valid s_ready s_rx_char       in         one received character
// result    m_valid m_ready m_tx_char m_tx_last  out   one reply character
//
// After reset the byte memory is cleared, one entry a cycle, all 2**MEM_ADDR_BITS
// entries; no item is taken meanwhile.
// A token character or a lone separator is only taken. A token end is accepted, then
// executed, then for X0 a memory read is done, then the reply steps one slot a cycle
// unless the result stalls: four slots for a status line, ten when a value is printed
// (a skipped leading zero still takes its step); an overflow reply skips the execute step.
// A stalled result holds the sequencer on its slot; no item is taken during a reply.
module serial_hex_monitor #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_char,
    output logic       m_tx_last
);
    import shm_pkg::*;

    shm_cmd_t cmd;
    shm_sts_t sts;

    shm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    shm_datapath #(
        .MEM_ADDR_BITS(MEM_ADDR_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .rx_char  (s_rx_char),
        .tx_char  (m_tx_char),
        .tx_last  (m_tx_last),
        .tx_valid (m_valid),
        .tx_ready (m_ready)
    );

endmodule

@@ tb/tb_serial_hex_monitor.sv @@
`timescale 1ns / 100ps

module tb_serial_hex_monitor;
    import shm_pkg::*;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int RANDOM_ITEMS = 185;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_char = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_char;
    logic       m_tx_last;

    // One expected reply character.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } reply_t;

    // One row of the directed table; a nonempty text gives the reply to expect.
    typedef struct {
        logic [7:0] ch;
        string      text;
    } row_t;

    reply_t      reply_queue[$];
    reply_t      step_replies[$];
    logic [7:0]  tok_buf[4];
    int unsigned tok_len;
    logic        tok_started;
    logic        tok_over;
    logic        halted;
    logic [15:0] regs[16];
    logic [7:0]  mem[MEM_DEPTH];
    int          mismatch_count = 0;
    longint      cycle_count = 0;

    serial_hex_monitor #(.MEM_ADDR_BITS(ADDR_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_char(s_rx_char),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tx_char(m_tx_char), .m_tx_last(m_tx_last)
    );

    always #6 aclk = ~aclk;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] d);
        return (d > 4'd9) ? 8'("A" + d - 10) : 8'("0" + d);
    endfunction

    function automatic void emit(input logic [7:0] c);
        reply_t r;
        r.ch = c;
        r.last = 1'b0;
        step_replies.push_back(r);
    endfunction

    function automatic void emit_value(input logic [15:0] v);
        logic lead;
        logic [3:0] d;
        lead = 1'b0;
        for (int sh = 12; sh >= 0; sh -= 4) begin
            d = v[sh +: 4];
            if (d != 0 || lead || sh == 0) begin
                lead = 1'b1;
                emit(nibble_char(d));
            end
        end
        emit(CH_CR);
        emit(CH_LF);
    endfunction

    function automatic logic [ADDR_BITS-1:0] linear_addr(input logic [15:0] seg,
                                                          input logic [15:0] off);
        logic [31:0] a;
        a = {12'h0, seg, 4'h0} + {16'h0, off};
        return a[ADDR_BITS-1:0];
    endfunction

    // Executes the finished token and returns its status code.
    function automatic logic [1:0] run_command();
        logic [7:0] head;
        logic [4:0] idx;
        logic [4:0] d;
        logic [15:0] v;
        head = tok_buf[0];
        idx = digit_of(tok_buf[1]);
        if (head == CH_R || head == CH_W || head == CH_X) begin
            if (tok_len != 2) return STAT_LEN;
            if (head == CH_R) begin
                if (!idx[4]) regs[IDX_VAL] = regs[idx[3:0]];
                emit_value(regs[IDX_VAL]);
                return idx[4] ? STAT_INDEX : STAT_OK;
            end
            if (head == CH_W) begin
                if (idx[4]) return STAT_INDEX;
                regs[idx[3:0]] = regs[IDX_VAL];
                return STAT_OK;
            end
            if (idx == 5'd0) begin
                regs[IDX_VAL] = {8'h00, mem[linear_addr(regs[IDX_DS], regs[IDX_SI])]};
                regs[IDX_SI] = regs[IDX_SI] + 16'd1;
                emit_value(regs[IDX_VAL]);
                return STAT_OK;
            end
            if (idx == 5'd1) begin
                mem[linear_addr(regs[IDX_ES], regs[IDX_DI])] = regs[IDX_VAL][7:0];
                regs[IDX_DI] = regs[IDX_DI] + 16'd1;
                return STAT_OK;
            end
            return (idx == 5'd2) ? STAT_OK : STAT_INDEX;
        end
        v = 16'h0;
        for (int i = 0; i < tok_len; i++) begin
            d = digit_of(tok_buf[i]);
            if (d[4]) return STAT_VALUE;
            v = {v[11:0], d[3:0]};
        end
        regs[IDX_VAL] = v;
        return STAT_OK;
    endfunction

    function automatic void emit_status(input logic [1:0] st);
        emit(CH_S);
        emit(nibble_char({2'b00, st}));
        emit(CH_CR);
        emit(CH_LF);
    endfunction

    function automatic void clear_token();
        foreach (tok_buf[i]) tok_buf[i] = 8'h00;
        tok_len = 0;
        tok_started = 1'b0;
        tok_over = 1'b0;
    endfunction

    // Predicts the reply characters of one received character.
    function automatic void predict_char(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        step_replies.delete();
        if (halted) return;
        if (c == CH_NUL || c == CH_EOS) begin
            if (tok_over) emit_status(STAT_LEN);
            else halted = 1'b1;
            clear_token();
        end else if (c <= CH_SPACE) begin
            if (!tok_started) return;
            if (tok_over) emit_status(STAT_LEN);
            else emit_status(run_command());
            clear_token();
        end else begin
            tok_started = 1'b1;
            if (tok_len >= 4) begin
                tok_over = 1'b1;
            end else begin
                if (c >= "a" && c <= "z") c = c - 8'h20;
                tok_buf[tok_len] = c;
                tok_len++;
            end
        end
        if (step_replies.size() > 0) step_replies[$].last = 1'b1;
    endfunction

    // Sends one character and queues its predicted replies.
    task automatic send_char(input logic [7:0] c, input string text);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_char <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        predict_char(c);
        // Typed-in replies must agree with the predictor as well.
        if (text.len() > 0) begin
            if (text.len() != step_replies.size()) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("table row %h: expected %0d chars, predicted %0d",
                             c, text.len(), step_replies.size());
            end else begin
                for (int i = 0; i < text.len(); i++) begin
                    if (text[i] != step_replies[i].ch) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("table row %h: char %0d expected %h predicted %h",
                                     c, i, text[i], step_replies[i].ch);
                    end
                end
            end
        end
        foreach (step_replies[i]) reply_queue.push_back(step_replies[i]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], "");
    endtask

    // Random well-formed tokens with random content, plus noise.
    function automatic string random_token();
        string hexd;
        string s;
        int k;
        int p;
        hexd = "0123456789ABCDEFabcdef";
        k = $urandom_range(0, 9);
        case (k)
            0, 1: begin
                p = $urandom_range(0, 21);
                s = $sformatf("%s%s", ($urandom_range(0, 1) ? "R" : "r"), hexd.substr(p, p));
            end
            2: begin
                p = $urandom_range(0, 15);
                s = {"W", hexd.substr(p, p)};
            end
            3: s = $sformatf("W%0d", $urandom_range(4, 9));
            4: s = $sformatf("X%0d", $urandom_range(0, 2));
            5: s = "X0";
            6, 7: begin
                s = "";
                repeat ($urandom_range(1, 4)) begin
                    p = $urandom_range(0, 21);
                    s = {s, hexd.substr(p, p)};
                end
            end
            default: begin
                s = "";
                repeat ($urandom_range(1, 7)) s = {s, string'(8'($urandom_range(8'h21, 8'hFE)))};
            end
        endcase
        return s;
    endfunction

    // Result side: random back-pressure and checking.
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (reply_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply %h last %b", m_tx_char, m_tx_last);
            end else begin
                exp_r = reply_queue.pop_front();
                if (exp_r.ch !== m_tx_char || exp_r.last !== m_tx_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reply mismatch: expected %h/%b actual %h/%b",
                                 exp_r.ch, exp_r.last, m_tx_char, m_tx_last);
                end
            end
        end
    end

    always @(negedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count % 2000 < 300) m_ready <= 1'b1;
        else if (r < 3) m_ready <= 1'b0;
        else if (r < 60) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 1) == 1);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    row_t table_rows[$];

    initial begin
        string tok;
        int sent;
        halted = 1'b0;
        clear_token();
        foreach (regs[i]) regs[i] = 16'h0;
        foreach (mem[i]) mem[i] = 8'h00;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: extremes, the R, W, X1 and value commands, and the odd cases.
        table_rows = '{
            '{8'h20, ""}, '{8'h01, ""},
            '{"R", ""}, '{"9", ""}, '{8'h20, "0\r\nS0\r\n"},
            '{"f", ""}, '{"F", ""}, '{"f", ""}, '{"f", ""}, '{8'h0A, "S0\r\n"},
            '{"R", ""}, '{"z", ""}, '{8'h20, "FFFF\r\nS3\r\n"},
            '{"W", ""}, '{"5", ""}, '{8'h09, "S0\r\n"},
            '{"X", ""}, '{"1", ""}, '{8'h20, ""},
            '{"X", ""}, '{"7", ""}, '{8'h20, "S3\r\n"},
            '{"G", ""}, '{8'h20, "S2\r\n"},
            '{"R", ""}, '{8'h20, "S1\r\n"}
        };
        foreach (table_rows[i]) send_char(table_rows[i].ch, table_rows[i].text);
        // Long token, ended by a separator and by end of stream.
        send_text("12345 ");
        send_text("ABCDEFX");
        send_char(8'hFF, "S1\r\n");
        send_text("W7 X0 X2 Wq ");
        send_text("7FFF W8 FFFF W5 X1 x1 W7 R5 ");
        send_char(8'hFE, "");
        send_char(8'h20, "");

        // Random part.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                send_char(8'($urandom_range(0, 255)), "");
                sent++;
            end else begin
                tok = random_token();
                send_text(tok);
                sent += tok.len();
                repeat ($urandom_range(1, 2)) begin
                    send_char(8'($urandom_range(1, 32)), "");
                    sent++;
                end
            end
        end
        // End of stream halts the block; later input must be ignored.
        send_char(8'h00, "");
        send_text("R9 ");
        send_char(8'hFF, "");
        s_valid <= 1'b0;

        while (reply_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && reply_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
